// File: rtl/euclidean_distance_isqrt_defines.svh
// ----------------------------------------------------------------------------
// Euclidean distance assertion macros
// Shared property shorthands for the distance block's checks.
// ----------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_ISQRT_DEFINES_SVH
`define EUCLIDEAN_DISTANCE_ISQRT_DEFINES_SVH

// same-cycle implication, skipped while in reset
`define EDI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped while in reset
`define EDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/edi_pkg.sv
// ----------------------------------------------------------------------------
// Euclidean distance package
// Widths, codes and interface types shared by the distance block modules.
// ----------------------------------------------------------------------------
package edi_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int SUM_BITS       = 37;
    localparam int DIST_BITS      = 26;
    localparam int SUM_PAIRS      = (SUM_BITS + 1) / 2;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [SUM_BITS-1:0]  SUM_MAX  = '1;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam logic       MODE_ALL    = 1'b0;
    localparam logic       MODE_SKIP   = 1'b1;
    localparam logic [2:0] ELEM_SKIP_A = 3'd4;
    localparam logic [2:0] ELEM_SKIP_B = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACC,
        ST_ROOT,
        ST_DONE
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic done;
    } t_back_ctl;

endpackage

// File: rtl/edi_front.sv
// ----------------------------------------------------------------------------
// Distance front end
// Accepts element pairs, forms the difference magnitude pushed into the work
// queue and pushes a zero magnitude for skipped elements.
// ----------------------------------------------------------------------------
module edi_front import edi_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_valid,
    input  logic                  i_mode,
    input  logic [2:0]            i_element,
    input  logic [VALUE_BITS-1:0] i_value_a,
    input  logic [VALUE_BITS-1:0] i_value_b,
    input  logic                  i_last,
    input  t_q_stat               i_q_stat,
    output logic                  o_stall,
    output logic                  o_push,
    output logic [VALUE_BITS:0]   o_mag,
    output logic                  o_last
);

    localparam int MAG_W = VALUE_BITS + 1;

    logic [MAG_W-1:0] diff;
    logic [MAG_W-1:0] mag;
    logic             skip;

    assign diff = {i_value_a[VALUE_BITS-1], i_value_a} - {i_value_b[VALUE_BITS-1], i_value_b};
    assign mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
    assign skip = (i_mode == MODE_SKIP) &&
                  ((i_element == ELEM_SKIP_A) || (i_element == ELEM_SKIP_B));

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;
    assign o_mag   = skip ? '0 : mag;
    assign o_last  = i_last;

endmodule

// File: rtl/edi_queue.sv
// ----------------------------------------------------------------------------
// Distance work queue
// Short FIFO that decouples the front end from the accumulate and root unit.
// ----------------------------------------------------------------------------
module edi_queue import edi_pkg::*; #(
    parameter int WIDTH = VALUE_BITS_DEF + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// File: rtl/edi_back.sv
// ----------------------------------------------------------------------------
// Distance back end
// Squares queued differences, accumulates with saturation and runs a
// bit-pair square root on the last pair of each query.
// ----------------------------------------------------------------------------
module edi_back import edi_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [VALUE_BITS:0]  i_mag,
    input  logic                 i_last,
    input  t_q_stat              i_q_stat,
    input  logic                 i_out_stall,
    output t_back_ctl            o_ctl,
    output logic                 o_out_valid,
    output logic [DIST_BITS-1:0] o_distance
);

    localparam int MAG_W = VALUE_BITS + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int ADD_W = ((SQ_W > SUM_BITS) ? SQ_W : SUM_BITS) + 1;
    localparam int NPAIR = SUM_PAIRS + FRAC_BITS;
    localparam int RAD_W = 2 * NPAIR;
    localparam int REM_W = NPAIR + 2;
    localparam int TRY_W = NPAIR + 4;
    localparam int CNT_W = $clog2(NPAIR);
    localparam int CMP_W = (NPAIR > DIST_BITS) ? NPAIR : DIST_BITS;

    t_back_state          r_state, n_state;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_last;
    logic [SQ_W-1:0]      r_sq;
    logic [SUM_BITS-1:0]  r_sum;
    logic [RAD_W-1:0]     r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [NPAIR-1:0]     r_root;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    logic [DIST_BITS-1:0] r_dist;

    logic                 do_pop;
    logic                 do_square;
    logic                 do_acc;
    logic                 do_step;
    logic                 do_out;
    logic                 step_end;

    logic [ADD_W-1:0]     sum_wide;
    logic [SUM_BITS-1:0]  sum_next;
    logic [TRY_W-1:0]     try_rem;
    logic [TRY_W-1:0]     trial;
    logic                 take;
    logic [DIST_BITS-1:0] dist_sat;

    assign step_end = (r_cnt == CNT_W'(NPAIR - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: n_state = ST_ACC;
            ST_ACC: begin
                n_state = r_last ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
                if (step_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        do_pop    = 1'b0;
        do_square = 1'b0;
        do_acc    = 1'b0;
        do_step   = 1'b0;
        do_out    = 1'b0;
        case (r_state)
            ST_IDLE:   do_pop    = !i_q_stat.empty;
            ST_SQUARE: do_square = 1'b1;
            ST_ACC:    do_acc    = 1'b1;
            ST_ROOT:   do_step   = 1'b1;
            ST_DONE:   do_out    = !r_out_valid || !i_out_stall;
            default: begin
                do_pop = 1'b0;
            end
        endcase
    end

    assign sum_wide = ADD_W'(r_sum) + ADD_W'(r_sq);
    assign sum_next = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(sum_wide);

    assign try_rem = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign take    = (try_rem >= trial);

    assign dist_sat = (CMP_W'(r_root) > CMP_W'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(r_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_acc) begin
                r_sum <= r_last ? '0 : sum_next;
            end
            if (do_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_mag  <= i_mag;
            r_last <= i_last;
        end
        if (do_square) begin
            r_sq <= r_mag * r_mag;
        end
        if (do_acc) begin
            r_rad  <= RAD_W'(sum_next) << (2 * FRAC_BITS);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end
        if (do_step) begin
            r_rad  <= r_rad << 2;
            r_rem  <= take ? REM_W'(try_rem - trial) : REM_W'(try_rem);
            r_root <= {r_root[NPAIR-2:0], take};
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (do_out) begin
            r_dist <= dist_sat;
        end
    end

    assign o_ctl.pop   = do_pop;
    assign o_ctl.done  = do_out;
    assign o_out_valid = r_out_valid;
    assign o_distance  = r_dist;

endmodule

// File: rtl/euclidean_distance_isqrt.sv
// Flow: a pair accepted while the back end idles is queued, popped, squared and summed;
// a last pair then adds 19 + FRAC_BITS square root steps and a registered output.
// Throughput: the back end takes a pair only once the last is summed and any root is out;
// the front end takes a pair every cycle while the 4-entry queue has room.
// Reset: synchronous, active low; empties the queue, clears the sum and the output valid.
// ----------------------------------------------------------------------------
// Euclidean distance with integer square root
// Sums squared differences of two vectors element by element and returns the
// fixed-point square root of the sum on the last pair of each query.
// ----------------------------------------------------------------------------
`include "euclidean_distance_isqrt_defines.svh"

module euclidean_distance_isqrt import edi_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [2:0]            i_element,
    input  logic [VALUE_BITS-1:0] i_value_a,
    input  logic [VALUE_BITS-1:0] i_value_b,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DIST_BITS-1:0]  o_distance
);

    localparam int ENTRY_W = VALUE_BITS + 2;

    t_q_stat             q_stat;
    t_back_ctl           back_ctl;
    logic                push;
    logic [VALUE_BITS:0] front_mag;
    logic                front_last;
    logic [ENTRY_W-1:0]  q_head;

    edi_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_valid   (i_in_valid),
        .i_mode    (i_mode),
        .i_element (i_element),
        .i_value_a (i_value_a),
        .i_value_b (i_value_b),
        .i_last    (i_last),
        .i_q_stat  (q_stat),
        .o_stall   (o_in_stall),
        .o_push    (push),
        .o_mag     (front_mag),
        .o_last    (front_last)
    );

    edi_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_last, front_mag}),
        .i_pop   (back_ctl.pop),
        .o_data  (q_head),
        .o_stat  (q_stat)
    );

    edi_back #(
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mag       (q_head[VALUE_BITS:0]),
        .i_last      (q_head[ENTRY_W-1]),
        .i_q_stat    (q_stat),
        .i_out_stall (i_out_stall),
        .o_ctl       (back_ctl),
        .o_out_valid (o_out_valid),
        .o_distance  (o_distance)
    );

    `EDI_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, back_ctl.pop, !q_stat.empty, "pop from empty queue")
    `EDI_ASSERT_NOW(a_full_empty_excl, i_clk, i_rst_n, q_stat.full, !q_stat.empty, "queue full and empty")
    `EDI_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, push && !back_ctl.pop, !q_stat.empty, "push lost")
    `EDI_ASSERT_NOW(a_out_from_root, i_clk, i_rst_n, $rose(o_out_valid), $past(back_ctl.done), "result without root")

endmodule
